// ===== rtl/hatd_pkg.sv =====
// ----------------------------------------------------------------------------
// hatd_pkg: shared definitions for the heading block
// Widths, scaling constants, the tangent table and the sequencer states.
// ----------------------------------------------------------------------------
package hatd_pkg;

  localparam int COORD_W = 16;
  localparam int MAG_W   = 17;
  localparam int REM_W   = 31;
  localparam int RATIO_W = 14;
  localparam int HEAD_W  = 9;
  localparam int CNT_W   = 4;

  localparam logic [CNT_W-1:0] DIV1_STEPS = 4'd14;
  localparam logic [CNT_W-1:0] DIV2_STEPS = 4'd3;

  localparam logic [REM_W-1:0]   RATIO_SCALE = 31'd10000;
  localparam logic [REM_W-1:0]   SMALL_MUL   = 31'd57;
  localparam logic [REM_W-1:0]   INTERP_MUL  = 31'd5;
  localparam logic [RATIO_W-1:0] SMALL_LIMIT = 14'd1000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_PREP2,
    S_DIV2,
    S_FIN
  } state_t;

  function automatic logic [RATIO_W-1:0] tan_at(input logic [3:0] idx);
    logic [RATIO_W-1:0] t;
    case (idx)
      4'd0:    t = 14'd875;
      4'd1:    t = 14'd1763;
      4'd2:    t = 14'd2679;
      4'd3:    t = 14'd3640;
      4'd4:    t = 14'd4663;
      4'd5:    t = 14'd5774;
      4'd6:    t = 14'd7002;
      4'd7:    t = 14'd8391;
      default: t = 14'd10000;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/heading_atan2_degrees.sv =====
// ----------------------------------------------------------------------------
// heading_atan2_degrees: whole-degree heading between two points
// Computes the heading from a start point to a target point as 0..359
// degrees using a shared iterative restoring divider.
// ----------------------------------------------------------------------------
// One request is taken while the block is idle; no new request is taken until
// its heading has been loaded into the output register. The request passes
// through the states S_DIV1, S_PREP2, S_DIV2 and S_FIN in that order, and S_FIN
// holds while a stalled result still waits. The single compare-subtract divider
// step is used 14 times for the ratio and 3 times for the rounded angle.
// A finished heading waits in the output register while the next request
// is taken.
module heading_atan2_degrees (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hatd_pkg::COORD_W-1:0]  in_from_x,
  input  logic [hatd_pkg::COORD_W-1:0]  in_from_y,
  input  logic [hatd_pkg::COORD_W-1:0]  in_to_x,
  input  logic [hatd_pkg::COORD_W-1:0]  in_to_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hatd_pkg::HEAD_W-1:0]   out_heading_deg
);
  import hatd_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [REM_W-1:0]   rem_r, dsr_r;
  logic [RATIO_W-1:0] q_r;
  logic [MAG_W-1:0]   minor_r, major_r;
  logic               swap_r, zero_r, xneg_r, yle_r, ylt_r, small_r;
  logic [3:0]         k_r;
  logic               out_valid_r;
  logic [HEAD_W-1:0]  heading_r;

  logic               accept, out_load;
  logic [MAG_W-1:0]   dxs, dys, dx, dy, minor, major;
  logic               swap;
  logic [REM_W-1:0]   step_rem;
  logic               step_bit;
  logic [3:0]         k;
  logic [RATIO_W-1:0] lo, d;
  logic [5:0]         angle;
  logic [6:0]         base;
  logic [HEAD_W-1:0]  heading;

  hatd_div_step u_step (
    .rem     (rem_r),
    .dsr     (dsr_r),
    .rem_out (step_rem),
    .q_bit   (step_bit)
  );

  assign dxs   = {in_to_x[15], in_to_x} - {in_from_x[15], in_from_x};
  assign dys   = {in_to_y[15], in_to_y} - {in_from_y[15], in_from_y};
  assign dx    = dxs[16] ? (~dxs + 17'd1) : dxs;
  assign dy    = dys[16] ? (~dys + 17'd1) : dys;
  assign swap  = (dy > dx);
  assign minor = swap ? dx : dy;
  assign major = swap ? dy : dx;

  always_comb begin
    k = 4'd8;
    for (int i = 7; i >= 1; i--) begin
      if (tan_at(4'(i)) >= q_r) begin
        k = 4'(i);
      end
    end
    lo = tan_at(k - 4'd1);
    d  = tan_at(k) - lo;
  end

  always_comb begin
    angle = small_r ? {3'b000, q_r[2:0]} : (6'(k_r) * 6'd5 + {3'b000, q_r[2:0]});
    if (zero_r) begin
      base = 7'd0;
    end else if (swap_r) begin
      base = 7'd90 - {1'b0, angle};
    end else begin
      base = {1'b0, angle};
    end
    if (xneg_r) begin
      heading = yle_r ? (9'(base) + 9'd180) : (9'd180 - 9'(base));
    end else if (ylt_r && base != 7'd0) begin
      heading = 9'd360 - 9'(base);
    end else begin
      heading = 9'(base);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DIV1;
          cnt_nxt   = DIV1_STEPS - 4'd1;
        end
      end
      S_DIV1: begin
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          state_nxt = S_PREP2;
        end
      end
      S_PREP2: begin
        state_nxt = S_DIV2;
        cnt_nxt   = DIV2_STEPS - 4'd1;
      end
      S_DIV2: begin
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != S_IDLE);
    accept   = in_valid && (state_r == S_IDLE);
    out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      minor_r <= minor;
      major_r <= major;
      swap_r  <= swap;
      zero_r  <= (major == 17'd0);
      xneg_r  <= $signed(in_to_x) < $signed(in_from_x);
      yle_r   <= $signed(in_to_y) <= $signed(in_from_y);
      ylt_r   <= $signed(in_to_y) < $signed(in_from_y);
      rem_r   <= 31'(minor) * RATIO_SCALE;
      dsr_r   <= {1'b0, major, 13'b0};
      q_r     <= '0;
    end
    case (state_r)
      S_DIV1, S_DIV2: begin
        rem_r <= step_rem;
        dsr_r <= dsr_r >> 1;
        q_r   <= {q_r[RATIO_W-2:0], step_bit};
      end
      S_PREP2: begin
        q_r <= '0;
        k_r <= k;
        if (q_r < SMALL_LIMIT) begin
          small_r <= 1'b1;
          rem_r   <= 31'(minor_r) * SMALL_MUL + 31'(major_r[MAG_W-1:1]);
          dsr_r   <= {12'b0, major_r, 2'b00};
        end else begin
          small_r <= 1'b0;
          rem_r   <= 31'(q_r - lo) * INTERP_MUL + 31'(d[RATIO_W-1:1]);
          dsr_r   <= {15'b0, d, 2'b00};
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      heading_r <= heading;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_heading_deg = heading_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DIV1))
    else $error("accepted request did not start the ratio division");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_deg < 9'd360))
    else $error("heading out of range");

  a_div2_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV2) |-> (cnt_r < DIV2_STEPS))
    else $error("angle division step count overrun");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !zero_r) |-> (angle <= 6'd45))
    else $error("base angle above 45 degrees");

endmodule

// ===== rtl/hatd_div_step.sv =====
// ----------------------------------------------------------------------------
// hatd_div_step: one restoring division step
// Compares the partial remainder with the aligned divisor and subtracts it
// when it fits, giving one quotient bit.
// ----------------------------------------------------------------------------
module hatd_div_step (
  input  logic [hatd_pkg::REM_W-1:0] rem,
  input  logic [hatd_pkg::REM_W-1:0] dsr,
  output logic [hatd_pkg::REM_W-1:0] rem_out,
  output logic                       q_bit
);
  import hatd_pkg::*;

  assign q_bit   = (rem >= dsr);
  assign rem_out = q_bit ? (rem - dsr) : rem;

endmodule

// ===== dv/heading_atan2_degrees_tb.sv =====
// ----------------------------------------------------------------------------
// heading_atan2_degrees_tb: self-checking bench for the heading block
// Sends point-pair requests and predicts the whole-degree heading of each.
// It compares every result in order against that prediction, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module heading_atan2_degrees_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hatd_pkg::*;

  localparam int NUM_RANDOM   = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 60;

  class heading_board;
    logic [HEAD_W-1:0] heading_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function automatic int unsigned tangent_step(int unsigned idx);
      int unsigned t;
      case (idx)
        0: t = 875;
        1: t = 1763;
        2: t = 2679;
        3: t = 3640;
        4: t = 4663;
        5: t = 5774;
        6: t = 7002;
        7: t = 8391;
        default: t = 10000;
      endcase
      return t;
    endfunction

    function automatic int unsigned octant_angle(longint unsigned minor,
                                                 longint unsigned major);
      longint unsigned ratio;
      longint unsigned lo;
      longint unsigned span;
      int unsigned k;
      if (major == 0) return 0;
      ratio = (64'd10000 * minor) / major;
      if (ratio < 1000) return int'((64'd57 * minor + major / 2) / major);
      k = 1;
      while (k < 8 && tangent_step(k) < ratio) k++;
      lo = tangent_step(k - 1);
      span = tangent_step(k) - lo;
      if (ratio < lo) ratio = lo;
      return 5 * k + int'((5 * (ratio - lo) + span / 2) / span);
    endfunction

    function automatic logic [HEAD_W-1:0] predict_heading(
        logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
        logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty);
      int x1, y1, x2, y2;
      longint unsigned dx, dy;
      int unsigned base, h;
      x1 = int'($signed(fx));
      y1 = int'($signed(fy));
      x2 = int'($signed(tx));
      y2 = int'($signed(ty));
      dx = (x2 >= x1) ? longint'(x2 - x1) : longint'(x1 - x2);
      dy = (y2 >= y1) ? longint'(y2 - y1) : longint'(y1 - y2);
      if (dx == 0 && dy == 0) base = 0;
      else if (dy <= dx) base = octant_angle(dy, dx);
      else base = 90 - octant_angle(dx, dy);
      if (x2 < x1) begin
        h = (y2 <= y1) ? base + 180 : 180 - base;
      end else begin
        h = (y2 < y1) ? 360 - base : base;
        if (h == 360) h = 0;
      end
      return h[HEAD_W-1:0];
    endfunction

    function void note_request(logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                               logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty);
      heading_q.push_back(predict_heading(fx, fy, tx, ty));
    endfunction

    function void check_heading(logic [HEAD_W-1:0] actual);
      logic [HEAD_W-1:0] want;
      if (heading_q.size() == 0) begin
        $error("heading_deg: expected none, actual %0d", actual);
        errors++;
      end else begin
        want = heading_q.pop_front();
        if (actual !== want) begin
          $error("heading_deg: expected %0d, actual %0d", want, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return heading_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [COORD_W-1:0] in_from_x = '0;
  logic [COORD_W-1:0] in_from_y = '0;
  logic [COORD_W-1:0] in_to_x = '0;
  logic [COORD_W-1:0] in_to_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [HEAD_W-1:0]  out_heading_deg;

  heading_board board = new();
  bit idle_on = 1'b1;
  int idle_cycles = 0;

  heading_atan2_degrees u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_from_x      (in_from_x),
    .in_from_y      (in_from_y),
    .in_to_x        (in_to_x),
    .in_to_y        (in_to_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_heading_deg(out_heading_deg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      board.note_request(in_from_x, in_from_y, in_to_x, in_to_y);
      idle_cycles <= 0;
    end else if (rst_n && out_valid && !out_stall) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_n && out_valid && !out_stall) board.check_heading(out_heading_deg);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("heading_atan2_degrees_tb failed");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  task automatic send_request(input logic [COORD_W-1:0] fx, input logic [COORD_W-1:0] fy,
                              input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_from_x <= fx;
    in_from_y <= fy;
    in_to_x   <= tx;
    in_to_y   <= ty;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic send_ratio(input int major, input int minor, input bit y_major);
    logic [COORD_W-1:0] fx, fy, dmaj, dmin;
    fx = 16'($urandom_range(0, 65535));
    fy = 16'($urandom_range(0, 65535));
    dmaj = major[COORD_W-1:0];
    dmin = minor[COORD_W-1:0];
    if ($urandom_range(0, 1)) dmaj = -dmaj;
    if ($urandom_range(0, 1)) dmin = -dmin;
    if (y_major) send_request(fx, fy, fx + dmin, fy + dmaj);
    else send_request(fx, fy, fx + dmaj, fy + dmin);
  endtask

  initial begin
    int kind, major, minor;
    logic [COORD_W-1:0] fx, fy, tx, ty;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_request(16'd100, 16'd200, 16'd100, 16'd200);
    send_request(16'd0, 16'd0, 16'd5, 16'd0);
    send_request(16'd0, 16'd0, -16'sd5, 16'd0);
    send_request(16'd0, 16'd0, 16'd0, 16'd7);
    send_request(16'd0, 16'd0, 16'd0, -16'sd7);
    send_request(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_request(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_request(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_request(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_request(16'h8000, 16'h0000, 16'h7fff, 16'h0000);
    send_request(16'h0000, 16'h7fff, 16'h0000, 16'h8000);
    send_request(16'd0, 16'd0, 16'd30000, -16'sd1);
    send_request(16'd0, 16'd0, 16'd1, 16'd1);
    send_request(16'd0, 16'd0, -16'sd1, -16'sd1);
    send_request(16'd0, 16'd0, -16'sd1, 16'd1);
    send_request(16'd0, 16'd0, 16'd10000, 16'd999);
    send_request(16'd0, 16'd0, 16'd10000, 16'd1000);
    send_request(16'd0, 16'd0, 16'd10000, 16'd875);
    send_request(16'd0, 16'd0, 16'd10000, 16'd8391);
    send_request(16'd0, 16'd0, 16'd10000, 16'd9999);
    send_request(16'd0, 16'd0, 16'd1763, -16'sd10000);
    send_request(16'd0, 16'd0, -16'sd3, 16'd2);
    send_request(16'd50, 16'd50, 16'd49, 16'd50);
    send_request(16'd0, 16'd0, 16'd2, 16'd1);
    wait_all_results();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      idle_on = !(i >= 120 && i < 180);
      if (i == 250) wait_all_results();
      kind = $urandom_range(0, 9);
      fx = 16'($urandom_range(0, 65535));
      fy = 16'($urandom_range(0, 65535));
      tx = 16'($urandom_range(0, 65535));
      ty = 16'($urandom_range(0, 65535));
      case (kind)
        4, 5: begin
          tx = fx + 16'($urandom_range(0, 400)) - 16'd200;
          ty = fy + 16'($urandom_range(0, 400)) - 16'd200;
        end
        6: tx = fx;
        7: ty = fy;
        8: begin
          tx = fx;
          ty = fy;
        end
        default: ;
      endcase
      if (kind == 9) begin
        major = $urandom_range(1, 32767);
        minor = int'((longint'(major) * $urandom_range(0, 10000)) / 10000);
        send_ratio(major, minor, 1'($urandom_range(0, 1)));
      end else begin
        send_request(fx, fy, tx, ty);
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("heading_atan2_degrees_tb passed");
    end else begin
      $display("heading_atan2_degrees_tb failed");
    end
    $finish;
  end

endmodule
